### rtl/core/llae_pkg.sv
package llae_pkg;

    localparam int MAX_COLS = 64;
    localparam int MAX_ROWS = 64;

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int DIM_MAX = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
    localparam int DIM_W = ($clog2(DIM_MAX + 1) > 7) ? $clog2(DIM_MAX + 1) : 7;

    localparam int MODE_W = 2;
    localparam int FIELD_W = 6;
    localparam int CNT_W = 13;
    localparam int RULE_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 7;

    localparam int CELL_TOTAL = MAX_COLS * MAX_ROWS;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam int COUNT_CAP = (CELL_TOTAL > (2 ** CNT_W - 1)) ? (2 ** CNT_W - 1) : CELL_TOTAL;

    localparam logic [CFG_IDX_W-1:0] CFG_RULE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    localparam logic [CFG_DATA_W-1:0] WIDTH_RESET = 7'd64;
    localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 7'd64;

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR   = 2'd0,
        MODE_TOGGLE  = 2'd1,
        MODE_ADVANCE = 2'd2,
        MODE_READ    = 2'd3
    } t_mode;

    typedef enum logic [RULE_W-1:0] {
        RULE_CONWAY   = 2'd0,
        RULE_SEEDS    = 2'd1,
        RULE_MAZE     = 2'd2,
        RULE_HIGHLIFE = 2'd3
    } t_rule;

    typedef struct packed {
        t_rule            rule;
        logic [DIM_W-1:0] cols;
        logic [DIM_W-1:0] rows;
    } t_cfg;

    typedef struct packed {
        logic                we;
        logic [ROW_W-1:0]    waddr;
        logic [MAX_COLS-1:0] wdata;
        logic [ROW_W-1:0]    raddr;
    } t_ram_req;

    typedef struct packed {
        logic             alive;
        logic [CNT_W-1:0] count;
    } t_result;

    function automatic logic next_state(t_rule rule, logic alive, logic [3:0] n);
        logic res;
        unique case (rule)
            RULE_CONWAY:   res = alive ? (n == 4'd2 || n == 4'd3) : (n == 4'd3);
            RULE_SEEDS:    res = alive ? 1'b0 : (n == 4'd2);
            RULE_MAZE:     res = alive ? (n >= 4'd1 && n <= 4'd5) : (n == 4'd3);
            RULE_HIGHLIFE: res = alive ? (n == 4'd2 || n == 4'd3) : (n == 4'd3 || n == 4'd6);
            default:       res = 1'b0;
        endcase
        return res;
    endfunction

endpackage

### rtl/core/llae_in_if.sv
interface llae_in_if;
    logic                              valid;
    logic                              ready;
    logic [llae_pkg::MODE_W-1:0]  mode;
    logic [llae_pkg::FIELD_W-1:0] col;
    logic [llae_pkg::FIELD_W-1:0] row;

    modport source (output valid, output mode, output col, output row, input ready);
    modport sink (input valid, input mode, input col, input row, output ready);
endinterface

### rtl/core/llae_out_if.sv
interface llae_out_if;
    logic                            valid;
    logic                            ready;
    logic                            cell_alive;
    logic [llae_pkg::CNT_W-1:0] live_count;

    modport source (output valid, output cell_alive, output live_count, input ready);
    modport sink (input valid, input cell_alive, input live_count, output ready);
endinterface

### rtl/core/life_like_automaton_engine_core.sv
// Channel   Direction  Payload                         Handshake
// i_in      sink       mode, col, row                  valid, ready
// o_out     source     cell_alive, live_count          valid, ready
// i_cfg_*   write      i_cfg_idx, i_cfg_data           i_cfg_we
//
// Clear writes every row of the grid memory; read, advance and toggle sweep the active grid
// of H rows by W columns row by row, toggle first flipping the addressed cell if inside it.
// The sweep handles one cell a cycle out of three row buffers,
// plus one memory read and one write-back slot per row of the single grid memory.
// After reset the grid memory is cleared row by row before the first item is taken.
// A result waits in the output register; a new item is taken only once the previous one is done.
module life_like_automaton_engine_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    llae_in_if.sink                              i_in,
    llae_out_if.source                           o_out,
    input  logic                                 i_cfg_we,
    input  logic [llae_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [llae_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    llae_pkg::t_rule                 r_rule;
    logic [llae_pkg::CFG_DATA_W-1:0] r_width;
    logic [llae_pkg::CFG_DATA_W-1:0] r_height;
    logic                            r_ovalid;
    logic                            r_oalive;
    logic [llae_pkg::CNT_W-1:0]      r_ocount;

    llae_pkg::t_cfg                  cfg;
    logic [llae_pkg::DIM_W-1:0]      width_ext;
    logic [llae_pkg::DIM_W-1:0]      height_ext;
    logic                            in_grid;
    logic                            idle;
    logic                            start;
    logic                            res_valid;
    logic                            res_ready;
    llae_pkg::t_result               res;
    llae_pkg::t_ram_req              ram_req;
    logic [llae_pkg::MAX_COLS-1:0]   ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rule <= llae_pkg::RULE_CONWAY;
            r_width <= llae_pkg::WIDTH_RESET;
            r_height <= llae_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                llae_pkg::CFG_RULE:   r_rule <= llae_pkg::t_rule'(i_cfg_data[llae_pkg::RULE_W-1:0]);
                llae_pkg::CFG_WIDTH:  r_width <= i_cfg_data;
                llae_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        width_ext = llae_pkg::DIM_W'(r_width);
        height_ext = llae_pkg::DIM_W'(r_height);
        cfg.rule = r_rule;
        if (width_ext == '0) begin
            cfg.cols = llae_pkg::DIM_W'(1);
        end else if (width_ext > llae_pkg::DIM_W'(llae_pkg::MAX_COLS)) begin
            cfg.cols = llae_pkg::DIM_W'(llae_pkg::MAX_COLS);
        end else begin
            cfg.cols = width_ext;
        end
        if (height_ext == '0) begin
            cfg.rows = llae_pkg::DIM_W'(1);
        end else if (height_ext > llae_pkg::DIM_W'(llae_pkg::MAX_ROWS)) begin
            cfg.rows = llae_pkg::DIM_W'(llae_pkg::MAX_ROWS);
        end else begin
            cfg.rows = height_ext;
        end
        in_grid = (llae_pkg::DIM_W'(i_in.col) < cfg.cols)
               && (llae_pkg::DIM_W'(i_in.row) < cfg.rows);
    end

    assign start = i_in.valid && idle;
    assign i_in.ready = idle;
    assign res_ready = !r_ovalid || o_out.ready;

    llae_ram #(
        .WIDTH (llae_pkg::MAX_COLS),
        .DEPTH (llae_pkg::MAX_ROWS)
    ) u_grid_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    llae_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_start     (start),
        .i_mode      (llae_pkg::t_mode'(i_in.mode)),
        .i_col       (llae_pkg::COL_W'(i_in.col)),
        .i_row       (llae_pkg::ROW_W'(i_in.row)),
        .i_inside    (in_grid),
        .o_idle      (idle),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_ram       (ram_req),
        .i_ram_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_oalive <= res.alive;
            r_ocount <= res.count;
        end
    end

    assign o_out.valid = r_ovalid;
    assign o_out.cell_alive = r_oalive;
    assign o_out.live_count = r_ocount;

    a_no_write_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !ram_req.we)
        else $error("grid memory written while the block is idle");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("second item taken before the first one finished");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (32'(o_out.live_count) <= llae_pkg::COUNT_CAP))
        else $error("live count exceeds the grid size");

    a_alive_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.cell_alive) |-> (o_out.live_count != '0))
        else $error("live addressed cell missing from the live count");

endmodule

### rtl/core/llae_ram.sv
module llae_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/llae_cell_eval.sv
module llae_cell_eval (
    input  logic [llae_pkg::MAX_COLS-1:0] i_above,
    input  logic [llae_pkg::MAX_COLS-1:0] i_cur,
    input  logic [llae_pkg::MAX_COLS-1:0] i_below,
    input  logic [llae_pkg::COL_W-1:0]    i_col,
    input  logic [llae_pkg::DIM_W-1:0]    i_cols,
    input  llae_pkg::t_rule               i_rule,
    input  logic                          i_advance,
    output logic                          o_next
);

    logic                         has_l;
    logic                         has_r;
    logic [llae_pkg::COL_W-1:0] col_l;
    logic [llae_pkg::COL_W-1:0] col_r;
    logic [3:0]                   sum_mid;
    logic [3:0]                   sum_l;
    logic [3:0]                   sum_r;
    logic [3:0]                   n;

    always_comb begin
        has_l = (i_col != '0);
        has_r = (llae_pkg::DIM_W'(i_col) + llae_pkg::DIM_W'(1)) < i_cols;
        col_l = i_col - llae_pkg::COL_W'(1);
        col_r = i_col + llae_pkg::COL_W'(1);
        sum_mid = 4'(i_above[i_col]) + 4'(i_below[i_col]);
        sum_l = has_l ? (4'(i_above[col_l]) + 4'(i_cur[col_l]) + 4'(i_below[col_l])) : 4'd0;
        sum_r = has_r ? (4'(i_above[col_r]) + 4'(i_cur[col_r]) + 4'(i_below[col_r])) : 4'd0;
        n = sum_mid + sum_l + sum_r;
        o_next = i_advance ? llae_pkg::next_state(i_rule, i_cur[i_col], n) : i_cur[i_col];
    end

endmodule

### rtl/core/llae_ctrl.sv
module llae_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  llae_pkg::t_cfg                i_cfg,
    input  logic                          i_start,
    input  llae_pkg::t_mode               i_mode,
    input  logic [llae_pkg::COL_W-1:0]    i_col,
    input  logic [llae_pkg::ROW_W-1:0]    i_row,
    input  logic                          i_inside,
    output logic                          o_idle,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output llae_pkg::t_result             o_res,
    output llae_pkg::t_ram_req            o_ram,
    input  logic [llae_pkg::MAX_COLS-1:0] i_ram_rdata
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_CLEAR  = 11'b00000000010,
        S_TOG_RD = 11'b00000000100,
        S_TOG_WR = 11'b00000001000,
        S_START  = 11'b00000010000,
        S_PRIME  = 11'b00000100000,
        S_FETCH  = 11'b00001000000,
        S_LATCH  = 11'b00010000000,
        S_CELL   = 11'b00100000000,
        S_WRITE  = 11'b01000000000,
        S_DONE   = 11'b10000000000
    } t_state;

    t_state                        r_state;
    llae_pkg::t_mode               r_mode;
    logic [llae_pkg::COL_W-1:0]    r_col;
    logic [llae_pkg::ROW_W-1:0]    r_row;
    logic                          r_inside;
    logic                          r_init;
    logic [llae_pkg::ROW_W-1:0]    r_r;
    logic [llae_pkg::COL_W-1:0]    r_c;
    logic [llae_pkg::MAX_COLS-1:0] r_above;
    logic [llae_pkg::MAX_COLS-1:0] r_cur;
    logic [llae_pkg::MAX_COLS-1:0] r_below;
    logic [llae_pkg::MAX_COLS-1:0] r_new;
    logic [llae_pkg::CNT_W-1:0]    r_count;
    logic                          r_alive;

    logic                          next_bit;
    logic                          last_row;
    logic                          last_col;
    logic [llae_pkg::MAX_COLS-1:0] toggle_mask;

    llae_cell_eval u_eval (
        .i_above   (r_above),
        .i_cur     (r_cur),
        .i_below   (r_below),
        .i_col     (r_c),
        .i_cols    (i_cfg.cols),
        .i_rule    (i_cfg.rule),
        .i_advance (r_mode == llae_pkg::MODE_ADVANCE),
        .o_next    (next_bit)
    );

    always_comb begin
        last_row = (llae_pkg::DIM_W'(r_r) + llae_pkg::DIM_W'(1)) == i_cfg.rows;
        last_col = (llae_pkg::DIM_W'(r_c) + llae_pkg::DIM_W'(1)) == i_cfg.cols;
        toggle_mask = llae_pkg::MAX_COLS'(1) << r_col;
    end

    always_comb begin
        o_ram = '0;
        o_ram.raddr = r_r + llae_pkg::ROW_W'(1);
        unique case (r_state)
            S_CLEAR: begin
                o_ram.we = 1'b1;
                o_ram.waddr = r_r;
            end
            S_TOG_RD: begin
                o_ram.raddr = r_row;
            end
            S_TOG_WR: begin
                o_ram.we = 1'b1;
                o_ram.waddr = r_row;
                o_ram.wdata = i_ram_rdata ^ toggle_mask;
            end
            S_START: begin
                o_ram.raddr = '0;
            end
            S_WRITE: begin
                o_ram.we = (r_mode == llae_pkg::MODE_ADVANCE);
                o_ram.waddr = r_r;
                o_ram.wdata = r_new;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_init <= 1'b1;
            r_r <= '0;
            r_count <= '0;
            r_alive <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_mode <= i_mode;
                        r_col <= i_col;
                        r_row <= i_row;
                        r_inside <= i_inside;
                        r_count <= '0;
                        r_alive <= 1'b0;
                        r_r <= '0;
                        unique case (i_mode)
                            llae_pkg::MODE_CLEAR:  r_state <= S_CLEAR;
                            llae_pkg::MODE_TOGGLE: r_state <= i_inside ? S_TOG_RD : S_START;
                            default:               r_state <= S_START;
                        endcase
                    end
                end
                S_CLEAR: begin
                    if (r_r == llae_pkg::ROW_W'(llae_pkg::MAX_ROWS - 1)) begin
                        r_init <= 1'b0;
                        r_state <= r_init ? S_IDLE : S_DONE;
                    end else begin
                        r_r <= r_r + llae_pkg::ROW_W'(1);
                    end
                end
                S_TOG_RD: begin
                    r_state <= S_TOG_WR;
                end
                S_TOG_WR: begin
                    r_state <= S_START;
                end
                S_START: begin
                    r_r <= '0;
                    r_state <= S_PRIME;
                end
                S_PRIME: begin
                    r_cur <= i_ram_rdata;
                    r_above <= '0;
                    r_state <= S_FETCH;
                end
                S_FETCH: begin
                    r_state <= S_LATCH;
                end
                S_LATCH: begin
                    r_below <= last_row ? '0 : i_ram_rdata;
                    r_new <= r_cur;
                    r_c <= '0;
                    r_state <= S_CELL;
                end
                S_CELL: begin
                    r_new[r_c] <= next_bit;
                    if (next_bit && r_count != llae_pkg::CNT_MAX) begin
                        r_count <= r_count + llae_pkg::CNT_W'(1);
                    end
                    if (r_inside && r_r == r_row && r_c == r_col) begin
                        r_alive <= next_bit;
                    end
                    if (last_col) begin
                        r_state <= S_WRITE;
                    end else begin
                        r_c <= r_c + llae_pkg::COL_W'(1);
                    end
                end
                S_WRITE: begin
                    r_above <= r_cur;
                    r_cur <= r_below;
                    if (last_row) begin
                        r_state <= S_DONE;
                    end else begin
                        r_r <= r_r + llae_pkg::ROW_W'(1);
                        r_state <= S_FETCH;
                    end
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_idle = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res.alive = r_alive;
    assign o_res.count = r_count;

endmodule
